// ----- sv/psnr_acc_pkg.sv -----
package psnr_acc_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int ERR_BITS     = 58;
  localparam int CNT_MAX_BITS = 28;
  localparam int SQ_BITS      = 2 * SAMPLE_BITS;
  localparam int FRAC_BITS    = 16;
  localparam int EXP_BITS     = 6;
  localparam int LOG_BITS     = EXP_BITS + FRAC_BITS;
  localparam int NORM_BITS    = 64;
  localparam int MANT_BITS    = 32;
  localparam int NORM_STEPS   = 6;
  localparam int FIFO_DEPTH   = 2;
  localparam int PSNR_BITS    = 16;

  localparam logic [17:0] TEN_LOG10_2_Q16 = 18'd197283;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EXACT     = 2'd1;
  localparam logic [1:0] STATUS_ZERO_PEAK = 2'd2;

  localparam logic signed [PSNR_BITS-1:0] PSNR_MAX = 16'sh7fff;
  localparam logic signed [PSNR_BITS-1:0] PSNR_MIN = 16'sh8000;

  localparam logic signed [SAMPLE_BITS-1:0] PEAK_RESET = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] orig_sample;
    logic signed [SAMPLE_BITS-1:0] approx_sample;
    logic                          last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [PSNR_BITS-1:0] psnr_db;
    logic [1:0]                  psnr_status;
  } out_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] peak;
    logic [ERR_BITS-1:0]           err_sum;
    logic [CNT_MAX_BITS-1:0]       count;
  } job_t;

endpackage

// ----- sv/psnr_acc_front.sv -----
module psnr_acc_front
  import psnr_acc_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     job_valid,
  input  logic     job_ready,
  output job_t     job_data
);

  logic                          s1_valid_r;
  logic                          s1_last_r;
  logic signed [SAMPLE_BITS-1:0] s1_orig_r;
  logic [SQ_BITS-1:0]            s1_sq_r;

  logic signed [SAMPLE_BITS-1:0] peak_r, peak_nxt;
  logic [ERR_BITS-1:0]           sum_r, sum_nxt;
  logic [COUNT_BITS-1:0]         cnt_r, cnt_nxt;

  logic signed [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS-1:0]        abs_diff;
  logic [ERR_BITS:0]             sum_wide;
  logic                          advance;
  logic                          in_xfer;

  assign diff     = {in_data.orig_sample[SAMPLE_BITS-1], in_data.orig_sample}
                  - {in_data.approx_sample[SAMPLE_BITS-1], in_data.approx_sample};
  assign abs_diff = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff) : diff[SAMPLE_BITS-1:0];

  assign advance  = s1_valid_r && (!s1_last_r || job_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  assign sum_wide = {1'b0, sum_r} + (ERR_BITS+1)'(s1_sq_r);

  always_comb begin
    peak_nxt = (s1_orig_r > peak_r) ? s1_orig_r : peak_r;
    sum_nxt  = sum_wide[ERR_BITS] ? {ERR_BITS{1'b1}} : sum_wide[ERR_BITS-1:0];
    cnt_nxt  = (cnt_r == {COUNT_BITS{1'b1}}) ? cnt_r : cnt_r + 1'b1;
  end

  assign job_valid        = s1_valid_r && s1_last_r;
  assign job_data.peak    = peak_nxt;
  assign job_data.err_sum = sum_nxt;
  assign job_data.count   = CNT_MAX_BITS'(cnt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      peak_r     <= PEAK_RESET;
      sum_r      <= '0;
      cnt_r      <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        if (s1_last_r) begin
          peak_r <= PEAK_RESET;
          sum_r  <= '0;
          cnt_r  <= '0;
        end else begin
          peak_r <= peak_nxt;
          sum_r  <= sum_nxt;
          cnt_r  <= cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_last_r <= in_data.last_sample;
      s1_orig_r <= in_data.orig_sample;
      s1_sq_r   <= abs_diff * abs_diff;
    end
  end

endmodule

// ----- sv/psnr_acc_fifo.sv -----
module psnr_acc_fifo
  import psnr_acc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  localparam int PTR_BITS = $clog2(FIFO_DEPTH);

  job_t                mem_r [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [PTR_BITS:0]   fill_r;
  logic                push;
  logic                pop;

  assign push_ready = (fill_r != (PTR_BITS+1)'(FIFO_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- sv/psnr_acc_log2.sv -----
module psnr_acc_log2
  import psnr_acc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [ERR_BITS-1:0] x,
  output logic                done,
  output logic [LOG_BITS-1:0] result
);

  localparam int STEP_BITS = 5;
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(NORM_STEPS + FRAC_BITS - 1);

  logic                  busy_r;
  logic                  done_r;
  logic [STEP_BITS-1:0]  step_r;
  logic [NORM_BITS-1:0]  xn_r;
  logic [EXP_BITS-1:0]   e_r;
  logic [FRAC_BITS-1:0]  frac_r;

  logic [6:0]            shamt;
  logic                  top_zero;
  logic [2*MANT_BITS-1:0] sq;
  logic [MANT_BITS:0]    q;
  logic                  norm_phase;

  assign norm_phase = (step_r < STEP_BITS'(NORM_STEPS));
  assign shamt      = 7'd32 >> step_r[2:0];
  assign top_zero   = ((xn_r >> (7'd64 - shamt)) == '0);
  assign sq         = xn_r[NORM_BITS-1 -: MANT_BITS] * xn_r[NORM_BITS-1 -: MANT_BITS];
  assign q          = sq[2*MANT_BITS-1:MANT_BITS-1];

  assign done   = done_r;
  assign result = {e_r, frac_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xn_r <= NORM_BITS'(x);
      e_r  <= {EXP_BITS{1'b1}};
    end else if (busy_r) begin
      if (norm_phase) begin
        if (top_zero) begin
          xn_r <= xn_r << shamt;
          e_r  <= e_r - shamt[EXP_BITS-1:0];
        end
      end else if (q[MANT_BITS]) begin
        xn_r[NORM_BITS-1 -: MANT_BITS] <= q[MANT_BITS:1];
        frac_r <= {frac_r[FRAC_BITS-2:0], 1'b1};
      end else begin
        xn_r[NORM_BITS-1 -: MANT_BITS] <= q[MANT_BITS-1:0];
        frac_r <= {frac_r[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- sv/psnr_acc_back.sv -----
module psnr_acc_back
  import psnr_acc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  output logic      job_ready,
  input  job_t      job_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_LOG   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam int L_BITS   = LOG_BITS + 2;
  localparam int MAG_BITS = L_BITS - 1 + 18;

  logic [2:0]                  state_r, state_nxt;
  logic [1:0]                  op_r;
  job_t                        job_r;
  logic [SQ_BITS-1:0]          psq_r;
  logic signed [L_BITS-1:0]    l_r;
  logic [MAG_BITS-1:0]         mag_r;
  logic                        neg_r;
  out_item_t                   res_r;

  logic [SAMPLE_BITS-1:0]      pm;
  logic [1:0]                  sel;
  logic                        log_start;
  logic [ERR_BITS-1:0]         log_x;
  logic                        log_done;
  logic [LOG_BITS-1:0]         log_res;
  logic signed [L_BITS-1:0]    log_ext;
  logic [L_BITS-2:0]           l_abs;
  logic [MAG_BITS:0]           rnd;
  logic [MAG_BITS-24:0]        r;
  logic signed [PSNR_BITS-1:0] fin_db;

  assign pm = job_data.peak[SAMPLE_BITS-1] ? SAMPLE_BITS'(-job_data.peak)
                                           : job_data.peak;

  assign job_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = res_r;

  assign sel       = (state_r == S_CHECK) ? 2'd0 : op_r + 1'b1;
  assign log_start = ((state_r == S_CHECK) && (job_r.err_sum != '0) && (job_r.peak != '0))
                  || ((state_r == S_LOG) && log_done && (op_r != 2'd2));

  always_comb begin
    unique case (sel)
      2'd0:    log_x = ERR_BITS'(psq_r);
      2'd1:    log_x = ERR_BITS'(job_r.count);
      default: log_x = job_r.err_sum;
    endcase
  end

  psnr_acc_log2 u_log2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (log_start),
    .x      (log_x),
    .done   (log_done),
    .result (log_res)
  );

  assign log_ext = $signed({2'b00, log_res});
  assign l_abs   = l_r[L_BITS-1] ? (L_BITS-1)'(-l_r) : l_r[L_BITS-2:0];
  assign rnd     = {1'b0, mag_r} + (MAG_BITS+1)'(1 << 23);
  assign r       = rnd[MAG_BITS:24];

  always_comb begin
    if (neg_r) begin
      fin_db = (r > (MAG_BITS-23)'(32768)) ? PSNR_MIN : PSNR_BITS'(-r);
    end else begin
      fin_db = (r > (MAG_BITS-23)'(32767)) ? PSNR_MAX : r[PSNR_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (log_start) begin
          state_nxt = S_LOG;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_LOG: begin
        if (log_done && (op_r == 2'd2)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:   state_nxt = S_FIN;
      S_FIN:   state_nxt = S_OUT;
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CHECK) begin
        op_r <= '0;
      end else if ((state_r == S_LOG) && log_done) begin
        op_r <= op_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          job_r <= job_data;
          psq_r <= pm * pm;
        end
      end
      S_CHECK: begin
        if (job_r.err_sum == '0) begin
          res_r.psnr_db     <= PSNR_MAX;
          res_r.psnr_status <= STATUS_EXACT;
        end else if (job_r.peak == '0) begin
          res_r.psnr_db     <= PSNR_MIN;
          res_r.psnr_status <= STATUS_ZERO_PEAK;
        end
      end
      S_LOG: begin
        if (log_done) begin
          unique case (op_r)
            2'd0:    l_r <= log_ext;
            2'd1:    l_r <= l_r + log_ext;
            default: l_r <= l_r - log_ext;
          endcase
        end
      end
      S_MUL: begin
        mag_r <= l_abs * TEN_LOG10_2_Q16;
        neg_r <= l_r[L_BITS-1];
      end
      S_FIN: begin
        res_r.psnr_db     <= fin_db;
        res_r.psnr_status <= STATUS_OK;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/psnr_accumulator_top.sv -----
// Each transfer is registered with its squared error, then added into the running state.
// Result: after the last sample's transfer, out_valid rises once three log2 passes of one
// shared normalize/square unit and the scale and round finish; zero error or peak skips them.
// Throughput: one sample per cycle unless a last sample waits on a full job queue; the back
// end takes a set once the last result leaves; a two-entry job queue lets new sets stream in.
// Reset: synchronous, active low; clears the running state, queue and any pending result.
module psnr_accumulator_top
  import psnr_acc_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_data, pop_data;

  psnr_acc_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job_data  (push_data)
  );

  psnr_acc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  psnr_acc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
